// ----- sv/emulation_prevention_remover_core_macros.svh -----
// Assertion macros for the emulation prevention remover core.
`ifndef EMULATION_PREVENTION_REMOVER_CORE_MACROS_SVH
`define EMULATION_PREVENTION_REMOVER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define EPR_ASSERT_IMPLY(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
        else $error("epr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define EPR_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
        else $error("epr assertion failed");

`else

`define EPR_ASSERT_IMPLY(label, clk_s, rst_s, ante, cons)
`define EPR_ASSERT_NEXT(label, clk_s, rst_s, ante, cons)

`endif

`endif

// ----- sv/epr_pkg.sv -----
// Shared widths, codes and types of the emulation prevention remover.
package epr_pkg;

    // Field widths.
    localparam int BYTE_W = 8;
    localparam int OFS_W  = 32;
    localparam int CNT_W  = 16;
    localparam int CODE_W = 3;
    localparam int IDX_W  = 2;
    localparam int RUN_W  = 2;
    localparam int PLAN_W = 2;

    localparam int OFFSET_BITS_DEFAULT = 32;

    // Byte values that matter to the escape scan.
    localparam logic [BYTE_W-1:0] BYTE_ZERO   = 8'h00;
    localparam logic [BYTE_W-1:0] BYTE_ONE    = 8'h01;
    localparam logic [BYTE_W-1:0] BYTE_TWO    = 8'h02;
    localparam logic [BYTE_W-1:0] BYTE_ESCAPE = 8'h03;

    // Zero run saturates here.
    localparam logic [RUN_W-1:0] RUN_FULL = 2'd2;

    // Conformance issue codes.
    localparam logic [CODE_W-1:0] ISSUE_NONE       = 3'd0;
    localparam logic [CODE_W-1:0] ISSUE_BAD_ESCAPE = 3'd1;
    localparam logic [CODE_W-1:0] ISSUE_ZERO3      = 3'd2;
    localparam logic [CODE_W-1:0] ISSUE_START_CODE = 3'd3;
    localparam logic [CODE_W-1:0] ISSUE_RESERVED   = 3'd4;
    localparam logic [CODE_W-1:0] ISSUE_FINAL_ZERO = 3'd5;

    // Status codes.
    localparam logic [CODE_W-1:0] ST_OK           = 3'd0;
    localparam logic [CODE_W-1:0] ST_SPAN_DONE    = 3'd1;
    localparam logic [CODE_W-1:0] ST_ISSUE_LIMIT  = 3'd2;
    localparam logic [CODE_W-1:0] ST_REMOVE_LIMIT = 3'd3;
    localparam logic [CODE_W-1:0] ST_SEG_LIMIT    = 3'd4;
    localparam logic [CODE_W-1:0] ST_HALTED       = 3'd5;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_SPAN_BASE    = 2'd0;
    localparam logic [IDX_W-1:0] REG_MAX_ISSUES   = 2'd1;
    localparam logic [IDX_W-1:0] REG_MAX_REMOVED  = 2'd2;
    localparam logic [IDX_W-1:0] REG_MAX_SEGMENTS = 2'd3;

    // Reset values of the limit registers.
    localparam logic [CNT_W-1:0] LIMIT_RESET = 16'd4096;

    typedef struct packed {
        logic [OFS_W-1:0] span_base_offset;
        logic [CNT_W-1:0] max_issues;
        logic [CNT_W-1:0] max_removed;
        logic [CNT_W-1:0] max_segments;
    } epr_cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              forwarded;
        logic              new_segment;
        logic [OFS_W-1:0]  source_offset;
        logic [OFS_W-1:0]  rbsp_offset;
        logic [CODE_W-1:0] first_issue;
        logic [CODE_W-1:0] second_issue;
        logic [CODE_W-1:0] status;
    } epr_result_t;

endpackage

// ----- sv/epr_if.sv -----
// Valid/ready channel interfaces for escaped input bytes and result items.
interface epr_ebsp_if;
    logic                        valid;
    logic                        ready;
    logic [epr_pkg::BYTE_W-1:0]  in_byte;
    logic                        is_last;

    modport source (output valid, output in_byte, output is_last, input ready);
    modport sink (input valid, input in_byte, input is_last, output ready);
endinterface

interface epr_rbsp_if;
    logic                        valid;
    logic                        ready;
    logic [epr_pkg::BYTE_W-1:0]  out_byte;
    logic                        forwarded;
    logic                        new_segment;
    logic [epr_pkg::OFS_W-1:0]   source_offset;
    logic [epr_pkg::OFS_W-1:0]   rbsp_offset;
    logic [epr_pkg::CODE_W-1:0]  first_issue;
    logic [epr_pkg::CODE_W-1:0]  second_issue;
    logic [epr_pkg::CODE_W-1:0]  status;

    modport source (output valid, output out_byte, output forwarded, output new_segment,
                    output source_offset, output rbsp_offset, output first_issue,
                    output second_issue, output status, input ready);
    modport sink (input valid, input out_byte, input forwarded, input new_segment,
                  input source_offset, input rbsp_offset, input first_issue,
                  input second_issue, input status, output ready);
endinterface

// ----- sv/epr_cfg_regs.sv -----
// Configuration register file of the emulation prevention remover.
module epr_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [epr_pkg::IDX_W-1:0]   cfg_index,
    input  logic [epr_pkg::OFS_W-1:0]   cfg_data,
    output epr_pkg::epr_cfg_t           cfg
);

    epr_pkg::epr_cfg_t cfg_reg;

    // Write one register per enabled cycle; limits keep their low bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.span_base_offset <= '0;
            cfg_reg.max_issues       <= epr_pkg::LIMIT_RESET;
            cfg_reg.max_removed      <= epr_pkg::LIMIT_RESET;
            cfg_reg.max_segments     <= epr_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                epr_pkg::REG_SPAN_BASE:    cfg_reg.span_base_offset <= cfg_data;
                epr_pkg::REG_MAX_ISSUES:   cfg_reg.max_issues   <= cfg_data[epr_pkg::CNT_W-1:0];
                epr_pkg::REG_MAX_REMOVED:  cfg_reg.max_removed  <= cfg_data[epr_pkg::CNT_W-1:0];
                epr_pkg::REG_MAX_SEGMENTS: cfg_reg.max_segments <= cfg_data[epr_pkg::CNT_W-1:0];
                default:                   cfg_reg.span_base_offset <= cfg_reg.span_base_offset;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/epr_step.sv -----
// Input register, span state and single-pass byte logic of the remover.
module epr_step #(
    parameter int OFFSET_BITS = epr_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [epr_pkg::BYTE_W-1:0]  in_byte,
    input  logic                        is_last,
    output logic                        in_ready,
    input  epr_pkg::epr_cfg_t           cfg,
    input  logic                        out_space,
    output logic                        res_valid,
    output epr_pkg::epr_result_t        res
);

    // Source offsets wrap at OFFSET_BITS; the port keeps 32 bits.
    localparam logic [epr_pkg::OFS_W-1:0] SRC_MASK = (OFFSET_BITS >= epr_pkg::OFS_W) ?
        {epr_pkg::OFS_W{1'b1}} : epr_pkg::OFS_W'((64'd1 << OFFSET_BITS) - 64'd1);

    logic                        in_valid_reg;
    logic [epr_pkg::BYTE_W-1:0]  in_byte_reg;
    logic                        is_last_reg;

    logic [epr_pkg::RUN_W-1:0]   zero_run_reg, zero_run_next;
    logic                        escape_pending_reg, escape_pending_next;
    logic                        prev_forwarded_reg, prev_forwarded_next;
    logic [epr_pkg::OFS_W-1:0]   byte_position_reg, byte_position_next;
    logic [epr_pkg::OFS_W-1:0]   rbsp_count_reg, rbsp_count_next;
    logic [epr_pkg::CNT_W-1:0]   issue_count_reg, issue_count_next;
    logic [epr_pkg::CNT_W-1:0]   removed_count_reg, removed_count_next;
    logic [epr_pkg::CNT_W-1:0]   segment_count_reg, segment_count_next;
    logic                        halted_reg, halted_next;

    logic                        advance;
    logic                        run_full;
    logic                        excl;
    logic                        starts;
    logic [epr_pkg::PLAN_W-1:0]  planned;
    logic [epr_pkg::CODE_W-1:0]  first_code;
    logic [epr_pkg::CODE_W-1:0]  second_code;
    logic [epr_pkg::CODE_W-1:0]  zero_kind;
    logic [epr_pkg::CNT_W:0]     issue_sum;
    logic [epr_pkg::CODE_W-1:0]  breach;
    logic [epr_pkg::OFS_W-1:0]   src_offset;

    // The held item moves on whenever the result register has room.
    assign advance   = in_valid_reg && out_space;
    assign in_ready  = !in_valid_reg || out_space;
    assign res_valid = advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= in_byte;
            is_last_reg <= is_last;
        end
    end

    // Escape detection and issue classification.
    always_comb
    begin
        run_full = (zero_run_reg == epr_pkg::RUN_FULL);
        excl     = run_full && (in_byte_reg == epr_pkg::BYTE_ESCAPE);
        starts   = !excl && !prev_forwarded_reg;

        if (in_byte_reg == epr_pkg::BYTE_ONE)
        begin
            zero_kind = epr_pkg::ISSUE_START_CODE;
        end
        else if (in_byte_reg == epr_pkg::BYTE_TWO)
        begin
            zero_kind = epr_pkg::ISSUE_RESERVED;
        end
        else
        begin
            zero_kind = epr_pkg::ISSUE_ZERO3;
        end

        planned     = '0;
        first_code  = epr_pkg::ISSUE_NONE;
        second_code = epr_pkg::ISSUE_NONE;
        if (escape_pending_reg && (in_byte_reg > epr_pkg::BYTE_ESCAPE))
        begin
            first_code = epr_pkg::ISSUE_BAD_ESCAPE;
            planned    = planned + 2'd1;
        end
        if (run_full && (in_byte_reg <= epr_pkg::BYTE_TWO))
        begin
            if (planned == '0)
            begin
                first_code = zero_kind;
            end
            else
            begin
                second_code = zero_kind;
            end
            planned = planned + 2'd1;
        end
        if (is_last_reg && (in_byte_reg == epr_pkg::BYTE_ZERO))
        begin
            if (planned == '0)
            begin
                first_code = epr_pkg::ISSUE_FINAL_ZERO;
            end
            else
            begin
                second_code = epr_pkg::ISSUE_FINAL_ZERO;
            end
            planned = planned + 2'd1;
        end
    end

    // Limit checks in the order issues, removals, segments.
    always_comb
    begin
        issue_sum = {1'b0, issue_count_reg} + {{(epr_pkg::CNT_W-epr_pkg::PLAN_W+1){1'b0}}, planned};
        if (issue_sum > {1'b0, cfg.max_issues})
        begin
            breach = epr_pkg::ST_ISSUE_LIMIT;
        end
        else if (excl && (removed_count_reg >= cfg.max_removed))
        begin
            breach = epr_pkg::ST_REMOVE_LIMIT;
        end
        else if (starts && (segment_count_reg >= cfg.max_segments))
        begin
            breach = epr_pkg::ST_SEG_LIMIT;
        end
        else
        begin
            breach = epr_pkg::ST_OK;
        end
        src_offset = (cfg.span_base_offset + byte_position_reg) & SRC_MASK;
    end

    // Result and next state.
    always_comb
    begin
        zero_run_next       = zero_run_reg;
        escape_pending_next = escape_pending_reg;
        prev_forwarded_next = prev_forwarded_reg;
        byte_position_next  = byte_position_reg;
        rbsp_count_next     = rbsp_count_reg;
        issue_count_next    = issue_count_reg;
        removed_count_next  = removed_count_reg;
        segment_count_next  = segment_count_reg;
        halted_next         = halted_reg;

        res               = '0;
        res.source_offset = src_offset;
        res.rbsp_offset   = rbsp_count_reg;

        if (halted_reg)
        begin
            res        = '0;
            res.status = epr_pkg::ST_HALTED;
        end
        else if (breach != epr_pkg::ST_OK)
        begin
            halted_next = 1'b1;
            res.status  = breach;
        end
        else
        begin
            issue_count_next = issue_sum[epr_pkg::CNT_W-1:0];
            if (excl)
            begin
                removed_count_next = removed_count_reg + 16'd1;
            end
            else
            begin
                if (starts)
                begin
                    segment_count_next = segment_count_reg + 16'd1;
                end
                rbsp_count_next = rbsp_count_reg + 32'd1;
                res.out_byte    = in_byte_reg;
                res.forwarded   = 1'b1;
                res.new_segment = starts;
            end
            res.first_issue  = first_code;
            res.second_issue = second_code;

            prev_forwarded_next = !excl;
            escape_pending_next = excl;
            if (excl || (in_byte_reg != epr_pkg::BYTE_ZERO))
            begin
                zero_run_next = '0;
            end
            else if (!run_full)
            begin
                zero_run_next = zero_run_reg + 2'd1;
            end
            byte_position_next = byte_position_reg + 32'd1;

            // End of span: clear every span counter.
            if (is_last_reg)
            begin
                zero_run_next       = '0;
                escape_pending_next = 1'b0;
                prev_forwarded_next = 1'b0;
                byte_position_next  = '0;
                rbsp_count_next     = '0;
                issue_count_next    = '0;
                removed_count_next  = '0;
                segment_count_next  = '0;
                res.status          = epr_pkg::ST_SPAN_DONE;
            end
        end
    end

    // Span state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_run_reg       <= '0;
            escape_pending_reg <= 1'b0;
            prev_forwarded_reg <= 1'b0;
            byte_position_reg  <= '0;
            rbsp_count_reg     <= '0;
            issue_count_reg    <= '0;
            removed_count_reg  <= '0;
            segment_count_reg  <= '0;
            halted_reg         <= 1'b0;
        end
        else if (advance)
        begin
            zero_run_reg       <= zero_run_next;
            escape_pending_reg <= escape_pending_next;
            prev_forwarded_reg <= prev_forwarded_next;
            byte_position_reg  <= byte_position_next;
            rbsp_count_reg     <= rbsp_count_next;
            issue_count_reg    <= issue_count_next;
            removed_count_reg  <= removed_count_next;
            segment_count_reg  <= segment_count_next;
            halted_reg         <= halted_next;
        end
    end

endmodule

// ----- sv/epr_out_reg.sv -----
// Result register that decouples the byte logic from the output channel.
module epr_out_reg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  epr_pkg::epr_result_t  load_data,
    output logic                  space,
    output logic                  out_valid,
    input  logic                  out_ready,
    output epr_pkg::epr_result_t  out_data
);

    logic                 valid_reg;
    epr_pkg::epr_result_t data_reg;

    // Room when empty or when the held item leaves this cycle.
    assign space     = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

// ----- sv/emulation_prevention_remover_core.sv -----
// Top level of the emulation prevention remover: EBSP bytes in, RBSP items out.
// A result item passes through the input register and then the result register.
// Throughput: one item per cycle when the result channel takes items, set by the
// single-pass byte logic between the input register and the result register,
// which updates the span state per item. Reset clears the span state, the halt
// flag and the pipeline, and returns the configuration registers to their defaults.
`include "emulation_prevention_remover_core_macros.svh"

module emulation_prevention_remover_core #(
    parameter int OFFSET_BITS = epr_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    epr_ebsp_if.sink                   ebsp,
    epr_rbsp_if.source                 rbsp,
    input  logic                       cfg_we,
    input  logic [epr_pkg::IDX_W-1:0]  cfg_index,
    input  logic [epr_pkg::OFS_W-1:0]  cfg_data
);

    epr_pkg::epr_cfg_t    cfg;
    epr_pkg::epr_result_t step_res;
    epr_pkg::epr_result_t out_res;
    logic                 step_valid;
    logic                 out_space;
    logic                 out_valid;
    logic                 res_normal;

    epr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    epr_step #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ebsp.valid),
        .in_byte   (ebsp.in_byte),
        .is_last   (ebsp.is_last),
        .in_ready  (ebsp.ready),
        .cfg       (cfg),
        .out_space (out_space),
        .res_valid (step_valid),
        .res       (step_res)
    );

    epr_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step_valid),
        .load_data (step_res),
        .space     (out_space),
        .out_valid (out_valid),
        .out_ready (rbsp.ready),
        .out_data  (out_res)
    );

    // Drive the result channel.
    assign rbsp.valid         = out_valid;
    assign rbsp.out_byte      = out_res.out_byte;
    assign rbsp.forwarded     = out_res.forwarded;
    assign rbsp.new_segment   = out_res.new_segment;
    assign rbsp.source_offset = out_res.source_offset;
    assign rbsp.rbsp_offset   = out_res.rbsp_offset;
    assign rbsp.first_issue   = out_res.first_issue;
    assign rbsp.second_issue  = out_res.second_issue;
    assign rbsp.status        = out_res.status;

    // A normal item carries an ok or span-complete status.
    assign res_normal = (out_res.status == epr_pkg::ST_OK) ||
                        (out_res.status == epr_pkg::ST_SPAN_DONE);

    // A forwarded byte only comes with an ok or span-complete status.
    `EPR_ASSERT_IMPLY(a_fwd_status, clk, rst_n, out_valid && out_res.forwarded, res_normal)

    // A new segment mark only appears on a forwarded byte.
    `EPR_ASSERT_IMPLY(a_seg_fwd, clk, rst_n, out_valid && out_res.new_segment, out_res.forwarded)

    // Once a breach or halt item is delivered, no normal item follows.
    `EPR_ASSERT_NEXT(a_halt_sticky, clk, rst_n, out_valid && rbsp.ready && !res_normal, !(out_valid && res_normal))

endmodule

// ----- test/emulation_prevention_remover_core_tb.sv -----
// Self-checking testbench for the emulation prevention remover core.
`timescale 1ns / 100ps

module emulation_prevention_remover_core_tb;

    // A taken byte passes through the input register and then the result register.
    localparam int PIPE_LAT    = 2;
    localparam int CYCLE_LIMIT = 200000;
    localparam int N_DIR       = 25;

    // One row of the directed table; typed rows carry their expected result.
    typedef struct packed {
        logic [epr_pkg::BYTE_W-1:0] in_byte;
        logic                       is_last;
        logic                       typed;
        epr_pkg::epr_result_t       res;
    } ebsp_row_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_we;
    logic [epr_pkg::IDX_W-1:0]    cfg_index;
    logic [epr_pkg::OFS_W-1:0]    cfg_data;

    epr_ebsp_if ebsp_ch ();
    epr_rbsp_if rbsp_ch ();

    emulation_prevention_remover_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .ebsp      (ebsp_ch),
        .rbsp      (rbsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow of the configuration and the span state.
    epr_pkg::epr_cfg_t          cfg_m;
    logic [epr_pkg::RUN_W-1:0]  zrun_m;
    logic                       esc_m;
    logic                       prev_fwd_m;
    logic [epr_pkg::OFS_W-1:0]  pos_m;
    logic [epr_pkg::OFS_W-1:0]  rbsp_m;
    logic [epr_pkg::CNT_W-1:0]  n_issue_m;
    logic [epr_pkg::CNT_W-1:0]  n_rem_m;
    logic [epr_pkg::CNT_W-1:0]  n_seg_m;
    logic                       halted_m;

    epr_pkg::epr_result_t pending_results[$];

    int tx_idle_pct;
    int rx_stall_pct;
    int hold_left;
    int cycle_count = 0;
    int err_count   = 0;
    int n_items;
    int n_spans     = 0;
    int n_removed   = 0;
    int n_segs      = 0;
    int n_flags     = 0;
    int n_halted    = 0;
    int breach_code = epr_pkg::ST_OK;

    // Directed bytes after reset: base 0 and default limits.
    ebsp_row_t dir_rows [N_DIR] = '{
        '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b1, 32'd0, 32'd0,
                              epr_pkg::ISSUE_NONE, epr_pkg::ISSUE_NONE, epr_pkg::ST_OK}},
        '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 32'd1, 32'd1,
                              epr_pkg::ISSUE_NONE, epr_pkg::ISSUE_NONE, epr_pkg::ST_OK}},
        '{8'h03, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 32'd2, 32'd2,
                              epr_pkg::ISSUE_NONE, epr_pkg::ISSUE_NONE, epr_pkg::ST_OK}},
        '{8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b1, 32'd3, 32'd2,
                              epr_pkg::ISSUE_BAD_ESCAPE, epr_pkg::ISSUE_NONE,
                              epr_pkg::ST_OK}},
        '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 32'd4, 32'd3,
                              epr_pkg::ISSUE_NONE, epr_pkg::ISSUE_NONE, epr_pkg::ST_OK}},
        '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 32'd5, 32'd4,
                              epr_pkg::ISSUE_NONE, epr_pkg::ISSUE_NONE, epr_pkg::ST_OK}},
        '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 32'd6, 32'd5,
                              epr_pkg::ISSUE_ZERO3, epr_pkg::ISSUE_NONE, epr_pkg::ST_OK}},
        '{8'h01, 1'b0, 1'b1, '{8'h01, 1'b1, 1'b0, 32'd7, 32'd6,
                              epr_pkg::ISSUE_START_CODE, epr_pkg::ISSUE_NONE,
                              epr_pkg::ST_OK}},
        '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 32'd8, 32'd7,
                              epr_pkg::ISSUE_NONE, epr_pkg::ISSUE_NONE, epr_pkg::ST_OK}},
        '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 32'd9, 32'd8,
                              epr_pkg::ISSUE_NONE, epr_pkg::ISSUE_NONE, epr_pkg::ST_OK}},
        '{8'h02, 1'b0, 1'b1, '{8'h02, 1'b1, 1'b0, 32'd10, 32'd9,
                              epr_pkg::ISSUE_RESERVED, epr_pkg::ISSUE_NONE,
                              epr_pkg::ST_OK}},
        '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 32'd11, 32'd10,
                              epr_pkg::ISSUE_NONE, epr_pkg::ISSUE_NONE, epr_pkg::ST_OK}},
        '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 32'd12, 32'd11,
                              epr_pkg::ISSUE_NONE, epr_pkg::ISSUE_NONE, epr_pkg::ST_OK}},
        '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b0, 32'd13, 32'd12,
                              epr_pkg::ISSUE_ZERO3, epr_pkg::ISSUE_FINAL_ZERO,
                              epr_pkg::ST_SPAN_DONE}},
        '{8'h03, 1'b1, 1'b1, '{8'h03, 1'b1, 1'b1, 32'd0, 32'd0,
                              epr_pkg::ISSUE_NONE, epr_pkg::ISSUE_NONE,
                              epr_pkg::ST_SPAN_DONE}},
        '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 32'd0, 32'd0,
                              epr_pkg::ISSUE_FINAL_ZERO, epr_pkg::ISSUE_NONE,
                              epr_pkg::ST_SPAN_DONE}},
        '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b1, 32'd0, 32'd0,
                              epr_pkg::ISSUE_NONE, epr_pkg::ISSUE_NONE, epr_pkg::ST_OK}},
        '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 32'd1, 32'd1,
                              epr_pkg::ISSUE_NONE, epr_pkg::ISSUE_NONE, epr_pkg::ST_OK}},
        '{8'h03, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 32'd2, 32'd2,
                              epr_pkg::ISSUE_NONE, epr_pkg::ISSUE_NONE, epr_pkg::ST_OK}},
        '{8'h03, 1'b0, 1'b1, '{8'h03, 1'b1, 1'b1, 32'd3, 32'd2,
                              epr_pkg::ISSUE_NONE, epr_pkg::ISSUE_NONE, epr_pkg::ST_OK}},
        '{8'h80, 1'b0, 1'b0, '0},
        '{8'h7F, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h03, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 32'd8, 32'd7,
                              epr_pkg::ISSUE_NONE, epr_pkg::ISSUE_NONE,
                              epr_pkg::ST_SPAN_DONE}}
    };

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Cycle counter and timeout.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles with %0d results outstanding.",
                 cycle_count, pending_results.size());
        $display("DONE: errors detected");
        $finish;
    end

    // Span counters go back to zero after the last byte of a span.
    function automatic void clear_span();
        zrun_m     = '0;
        esc_m      = 1'b0;
        prev_fwd_m = 1'b0;
        pos_m      = '0;
        rbsp_m     = '0;
        n_issue_m  = '0;
        n_rem_m    = '0;
        n_seg_m    = '0;
    endfunction

    // Works out the result of one escaped byte and advances the shadow state.
    function automatic epr_pkg::epr_result_t scan_byte(input logic [epr_pkg::BYTE_W-1:0] v,
                                                       input logic last);
        epr_pkg::epr_result_t       r;
        logic                       drop;
        logic                       fwd;
        logic                       starts;
        logic [epr_pkg::CODE_W-1:0] kind;
        logic [epr_pkg::CODE_W-1:0] st;
        int                         planned;
        r       = '0;
        st      = epr_pkg::ST_OK;
        planned = 0;
        if (halted_m)
        begin
            r.status = epr_pkg::ST_HALTED;
            return r;
        end
        r.source_offset = cfg_m.span_base_offset + pos_m;
        r.rbsp_offset   = rbsp_m;
        drop   = (zrun_m >= epr_pkg::RUN_FULL) && (v == epr_pkg::BYTE_ESCAPE);
        fwd    = !drop;
        starts = fwd && !prev_fwd_m;

        // Conformance issues, at most two per byte.
        if (esc_m && v > epr_pkg::BYTE_ESCAPE)
        begin
            r.first_issue = epr_pkg::ISSUE_BAD_ESCAPE;
            planned++;
        end
        if (zrun_m >= epr_pkg::RUN_FULL && v <= epr_pkg::BYTE_TWO)
        begin
            kind = (v == epr_pkg::BYTE_ONE) ? epr_pkg::ISSUE_START_CODE :
                   (v == epr_pkg::BYTE_TWO) ? epr_pkg::ISSUE_RESERVED : epr_pkg::ISSUE_ZERO3;
            if (planned == 0)
                r.first_issue = kind;
            else
                r.second_issue = kind;
            planned++;
        end
        if (last && v == epr_pkg::BYTE_ZERO)
        begin
            if (planned == 0)
                r.first_issue = epr_pkg::ISSUE_FINAL_ZERO;
            else
                r.second_issue = epr_pkg::ISSUE_FINAL_ZERO;
            planned++;
        end

        // Limit checks in priority order; a breach halts and changes nothing else.
        if (32'(n_issue_m) + planned > 32'(cfg_m.max_issues))
            st = epr_pkg::ST_ISSUE_LIMIT;
        else if (drop && n_rem_m >= cfg_m.max_removed)
            st = epr_pkg::ST_REMOVE_LIMIT;
        else if (starts && n_seg_m >= cfg_m.max_segments)
            st = epr_pkg::ST_SEG_LIMIT;
        if (st != epr_pkg::ST_OK)
        begin
            halted_m       = 1'b1;
            r.first_issue  = epr_pkg::ISSUE_NONE;
            r.second_issue = epr_pkg::ISSUE_NONE;
            r.status       = st;
            return r;
        end

        n_issue_m = n_issue_m + epr_pkg::CNT_W'(planned);
        if (drop)
        begin
            n_rem_m = n_rem_m + 1'b1;
        end
        else
        begin
            if (starts)
                n_seg_m = n_seg_m + 1'b1;
            rbsp_m        = rbsp_m + 1'b1;
            r.out_byte    = v;
            r.forwarded   = 1'b1;
            r.new_segment = starts;
        end
        prev_fwd_m = fwd;
        esc_m      = drop;
        if (drop || v != epr_pkg::BYTE_ZERO)
            zrun_m = '0;
        else if (zrun_m < epr_pkg::RUN_FULL)
            zrun_m = zrun_m + 1'b1;
        pos_m = pos_m + 1'b1;
        if (last)
        begin
            clear_span();
            r.status = epr_pkg::ST_SPAN_DONE;
        end
        return r;
    endfunction

    // Receiver: random stalls, or a long hold-off while hold_left runs down.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rbsp_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            rbsp_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
        begin
            rbsp_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    function automatic void check_field(input string name,
                                        input logic [epr_pkg::OFS_W-1:0] want,
                                        input logic [epr_pkg::OFS_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_count++;
        end
    endfunction

    // Compare every result item with the oldest expectation.
    always @(posedge clk)
    begin
        epr_pkg::epr_result_t want;
        if (rst_n && rbsp_ch.valid && rbsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result item with no expectation: status %0d", rbsp_ch.status);
                err_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("out_byte", want.out_byte, rbsp_ch.out_byte);
                check_field("forwarded", want.forwarded, rbsp_ch.forwarded);
                check_field("new_segment", want.new_segment, rbsp_ch.new_segment);
                check_field("source_offset", want.source_offset, rbsp_ch.source_offset);
                check_field("rbsp_offset", want.rbsp_offset, rbsp_ch.rbsp_offset);
                check_field("first_issue", want.first_issue, rbsp_ch.first_issue);
                check_field("second_issue", want.second_issue, rbsp_ch.second_issue);
                check_field("status", want.status, rbsp_ch.status);
                if (want.status == epr_pkg::ST_OK || want.status == epr_pkg::ST_SPAN_DONE)
                begin
                    if (!want.forwarded)
                        n_removed++;
                    if (want.new_segment)
                        n_segs++;
                    if (want.first_issue != epr_pkg::ISSUE_NONE)
                        n_flags++;
                    if (want.second_issue != epr_pkg::ISSUE_NONE)
                        n_flags++;
                    if (want.status == epr_pkg::ST_SPAN_DONE)
                        n_spans++;
                end
                else if (want.status == epr_pkg::ST_HALTED)
                begin
                    n_halted++;
                end
                else
                begin
                    breach_code = want.status;
                end
            end
        end
    end

    // Offer one byte, with a random gap first, and record its expected result.
    task automatic send_item(input logic [epr_pkg::BYTE_W-1:0] v, input logic last,
                             input logic typed, input epr_pkg::epr_result_t typed_res);
        epr_pkg::epr_result_t predicted;
        if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            ebsp_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < tx_idle_pct)
                @(posedge clk);
        end
        ebsp_ch.valid   <= 1'b1;
        ebsp_ch.in_byte <= v;
        ebsp_ch.is_last <= last;
        @(posedge clk);
        while (!ebsp_ch.ready)
            @(posedge clk);
        predicted = scan_byte(v, last);
        pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
        n_items++;
    endtask

    // Stop sending and let every expected result come back.
    task automatic wait_idle();
        ebsp_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [epr_pkg::IDX_W-1:0] idx,
                             input logic [epr_pkg::OFS_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            epr_pkg::REG_SPAN_BASE:    cfg_m.span_base_offset = data;
            epr_pkg::REG_MAX_ISSUES:   cfg_m.max_issues       = data[epr_pkg::CNT_W-1:0];
            epr_pkg::REG_MAX_REMOVED:  cfg_m.max_removed      = data[epr_pkg::CNT_W-1:0];
            epr_pkg::REG_MAX_SEGMENTS: cfg_m.max_segments     = data[epr_pkg::CNT_W-1:0];
            default: ;
        endcase
    endtask

    // Write all four registers back to back; the block must be idle.
    task automatic set_config(input logic [epr_pkg::OFS_W-1:0] base,
                              input logic [epr_pkg::CNT_W-1:0] mi,
                              input logic [epr_pkg::CNT_W-1:0] mr,
                              input logic [epr_pkg::CNT_W-1:0] ms);
        write_reg(epr_pkg::REG_SPAN_BASE, base);
        write_reg(epr_pkg::REG_MAX_ISSUES, {16'd0, mi});
        write_reg(epr_pkg::REG_MAX_REMOVED, {16'd0, mr});
        write_reg(epr_pkg::REG_MAX_SEGMENTS, {16'd0, ms});
        cfg_we <= 1'b0;
    endtask

    // One span built from escape patterns, start-code look-alikes and noise.
    task automatic send_span(input int len);
        logic [epr_pkg::BYTE_W-1:0] span_q[$];
        int                         pick;
        while (span_q.size() < len)
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1, 2, 3: span_q = {span_q, 8'($urandom_range(0, 255))};
                4, 5, 6:
                begin
                    span_q = {span_q, epr_pkg::BYTE_ZERO, epr_pkg::BYTE_ZERO,
                              epr_pkg::BYTE_ESCAPE, 8'($urandom_range(0, 3))};
                end
                7:
                begin
                    span_q = {span_q, epr_pkg::BYTE_ZERO, epr_pkg::BYTE_ZERO,
                              epr_pkg::BYTE_ESCAPE, 8'($urandom_range(0, 255))};
                end
                8:
                begin
                    span_q = {span_q, epr_pkg::BYTE_ZERO, epr_pkg::BYTE_ZERO,
                              8'($urandom_range(0, 2))};
                end
                default: span_q = {span_q, epr_pkg::BYTE_ZERO};
            endcase
        end
        for (int i = 0; i < len; i++)
            send_item(span_q[i], i == len - 1, 1'b0, '0);
    endtask

    // Spans of mostly moderate length, some of one to three bytes.
    task automatic run_spans(input int count);
        int start;
        start = n_items;
        while (n_items - start < count)
        begin
            if ($urandom_range(0, 7) == 0)
                send_span($urandom_range(1, 3));
            else
                send_span($urandom_range(4, 48));
        end
    endtask

    initial
    begin
        int target;
        int tight;
        int guard;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        ebsp_ch.valid   = 1'b0;
        ebsp_ch.in_byte = '0;
        ebsp_ch.is_last = 1'b0;
        n_items         = 0;
        hold_left       = 0;
        tx_idle_pct     = 21;
        rx_stall_pct    = 56;
        cfg_m.span_base_offset = '0;
        cfg_m.max_issues       = epr_pkg::LIMIT_RESET;
        cfg_m.max_removed      = epr_pkg::LIMIT_RESET;
        cfg_m.max_segments     = epr_pkg::LIMIT_RESET;
        halted_m = 1'b0;
        clear_span();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed bytes on the reset configuration.
        for (int i = 0; i < N_DIR; i++)
            send_item(dir_rows[i].in_byte, dir_rows[i].is_last, dir_rows[i].typed,
                      dir_rows[i].res);
        wait_idle();

        // Widest limits, random base; one long receiver hold-off midway.
        set_config($urandom, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_spans(300);
        hold_left = 90;
        run_spans(300);
        wait_idle();

        // Base just under the wrap point, random limits above any span's needs.
        tx_idle_pct  = 56;
        rx_stall_pct = 21;
        set_config(32'hFFFF_FFFF - $urandom_range(0, 63),
                   epr_pkg::CNT_W'($urandom_range(200, 65535)),
                   epr_pkg::CNT_W'($urandom_range(200, 65535)),
                   epr_pkg::CNT_W'($urandom_range(200, 65535)));
        run_spans(600);
        wait_idle();

        // Full rate, base zero, reset limits; hold-off and a full drain midway.
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        set_config(32'd0, epr_pkg::LIMIT_RESET, epr_pkg::LIMIT_RESET, epr_pkg::LIMIT_RESET);
        run_spans(250);
        hold_left = 120;
        run_spans(150);
        wait_idle();
        run_spans(150);
        wait_idle();

        // One limit at zero or one so that it breaches; everything after is halted.
        target = $urandom_range(1, 3);
        tight  = $urandom_range(0, 1);
        set_config($urandom,
                   (target == 1) ? epr_pkg::CNT_W'(tight) : 16'hFFFF,
                   (target == 2) ? epr_pkg::CNT_W'(tight) : 16'hFFFF,
                   (target == 3) ? epr_pkg::CNT_W'(tight) : 16'hFFFF);
        send_item(epr_pkg::BYTE_ZERO, 1'b0, 1'b0, '0);
        send_item(epr_pkg::BYTE_ZERO, 1'b0, 1'b0, '0);
        send_item(epr_pkg::BYTE_ZERO, 1'b0, 1'b0, '0);
        send_item(epr_pkg::BYTE_ZERO, 1'b1, 1'b0, '0);
        guard = 0;
        while (!halted_m && guard < 60)
        begin
            send_span($urandom_range(4, 48));
            guard++;
        end
        repeat (16) send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
        wait_idle();
        repeat (8) @(posedge clk);

        $display("Checked %0d bytes over %0d spans: %0d removed, %0d segments, %0d issue flags.",
                 n_items, n_spans, n_removed, n_segs, n_flags);
        $display("Breach status %0d on the limit set to %0d, then %0d halted items.",
                 breach_code, tight, n_halted);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
